// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the radix-prefixed number parser.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that an antecedent implies a consequent in the cycle after it.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rpup_pkg.sv =====
// Package for the radix-prefixed unsigned parser: phase codes, radix and
// character constants, the parser state type and the digit-value function.
// No dependencies.
package rpup_pkg;

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_LEAD   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam logic [4:0] RADIX_2  = 5'd2;
  localparam logic [4:0] RADIX_8  = 5'd8;
  localparam logic [4:0] RADIX_10 = 5'd10;
  localparam logic [4:0] RADIX_16 = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] ALPHA_OFFSET = 8'd7;
  localparam logic [7:0] ALPHA_FIRST  = 8'd17;
  localparam logic [7:0] DIGIT_HUGE   = 8'hFF;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  radix;
    logic [31:0] accum;
  } state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  radix_used;
  } result_t;

  // Digit value of a byte, saturated to DIGIT_HUGE where the true value
  // wraps below zero, since such a value ends the parse in every radix.
  function automatic logic [7:0] digit_of(input logic [7:0] b);
    logic [7:0] d;
    logic [7:0] m;
    begin
      d = b - CH_ZERO;
      m = d & ~CASE_BIT;
      if (b < CH_ZERO) begin
        digit_of = DIGIT_HUGE;
      end else if (d < ALPHA_FIRST) begin
        digit_of = d;
      end else if (m < ALPHA_OFFSET) begin
        digit_of = DIGIT_HUGE;
      end else begin
        digit_of = m - ALPHA_OFFSET;
      end
    end
  endfunction

endpackage

// ===== hw/rtl/rpup_step.sv =====
// Combinational next-state logic of the parser for one character item.
// Depends on rpup_pkg for the state type, phase codes and digit function.
module rpup_step (
  input  rpup_pkg::state_t  cur,
  input  logic [7:0]        ch,
  input  logic              first,
  output rpup_pkg::state_t  nxt,
  output logic              emit,
  output rpup_pkg::result_t res
);

  rpup_pkg::state_t st;
  rpup_pkg::state_t base;
  logic             do_take;
  logic [7:0]       dval;
  logic [31:0]      scaled;

  always_comb begin
    if (first) begin
      st.phase = rpup_pkg::PH_SIGN;
      st.radix = rpup_pkg::RADIX_10;
      st.accum = '0;
    end else begin
      st = cur;
    end
  end

  always_comb begin
    base    = st;
    do_take = 1'b0;
    unique case (st.phase)
      rpup_pkg::PH_SIGN: begin
        if (ch == rpup_pkg::CH_PLUS) begin
          base.phase = rpup_pkg::PH_LEAD;
        end else if (ch == rpup_pkg::CH_ZERO) begin
          base.phase = rpup_pkg::PH_ZERO;
        end else begin
          do_take = 1'b1;
        end
      end
      rpup_pkg::PH_LEAD: begin
        if (ch == rpup_pkg::CH_ZERO) begin
          base.phase = rpup_pkg::PH_ZERO;
        end else begin
          do_take = 1'b1;
        end
      end
      rpup_pkg::PH_ZERO: begin
        base.accum = '0;
        base.phase = rpup_pkg::PH_DIGITS;
        if (ch == rpup_pkg::CH_X) begin
          base.radix = rpup_pkg::RADIX_16;
        end else if (ch == rpup_pkg::CH_O) begin
          base.radix = rpup_pkg::RADIX_8;
        end else if (ch == rpup_pkg::CH_B) begin
          base.radix = rpup_pkg::RADIX_2;
        end else begin
          base.radix = rpup_pkg::RADIX_10;
          do_take    = 1'b1;
        end
      end
      rpup_pkg::PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: begin
        base.phase = rpup_pkg::PH_DONE;
      end
    endcase
  end

  assign dval = rpup_pkg::digit_of(ch);

  always_comb begin
    unique case (base.radix)
      rpup_pkg::RADIX_2:  scaled = {base.accum[30:0], 1'b0};
      rpup_pkg::RADIX_8:  scaled = {base.accum[28:0], 3'b000};
      rpup_pkg::RADIX_16: scaled = {base.accum[27:0], 4'b0000};
      default:            scaled = {base.accum[28:0], 3'b000} + {base.accum[30:0], 1'b0};
    endcase
  end

  always_comb begin
    nxt            = base;
    emit           = 1'b0;
    res.value      = base.accum;
    res.radix_used = base.radix;
    if (do_take) begin
      if (dval >= {3'b000, base.radix}) begin
        emit      = 1'b1;
        nxt.phase = rpup_pkg::PH_DONE;
      end else begin
        nxt.accum = scaled + {28'd0, dval[3:0]};
        nxt.phase = rpup_pkg::PH_DIGITS;
      end
    end
  end

endmodule

// ===== hw/rtl/radix_prefixed_unsigned_parser.sv =====
// Radix-prefixed unsigned parser: input register, parser state and result register.
// Depends on rpup_pkg, rpup_step and assert_macros.svh.
//
// The block takes one character item per cycle while no result waits for
// out_ready: the parser state (phase, radix and a 32-bit accumulator) closes
// its loop through a shift-and-add step, since every radix is a power of two
// or ten. An item is held in the input register, and its result, if it
// causes one, is then loaded into the result register. An item with first
// set starts a new string and drops any parse in progress. A result waiting
// for out_ready stalls the input register and the parser state; ready drops
// once the input register is full as well.
`include "assert_macros.svh"

module radix_prefixed_unsigned_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [4:0]  radix_used
);

  logic              stage_valid;
  logic [7:0]        stage_ch;
  logic              stage_first;
  logic              stage_adv;
  rpup_pkg::state_t  state;
  rpup_pkg::state_t  state_next;
  logic              emit;
  rpup_pkg::result_t res;
  logic              load_result;
  logic              stalled;
  logic              radix_ok;
  logic              parse_done;

  assign stage_adv   = stage_valid && (!out_valid || out_ready);
  assign in_ready    = !stage_valid || stage_adv;
  assign load_result = stage_adv && emit;

  rpup_step u_step (
    .cur   (state),
    .ch    (stage_ch),
    .first (stage_first),
    .nxt   (state_next),
    .emit  (emit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_ch    <= ch;
      stage_first <= first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= rpup_pkg::PH_DONE;
      state.radix <= rpup_pkg::RADIX_10;
      state.accum <= '0;
    end else if (stage_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      value      <= res.value;
      radix_used <= res.radix_used;
    end
  end

  assign stalled    = stage_valid && out_valid && !out_ready;
  assign parse_done = (state.phase == rpup_pkg::PH_DONE);
  assign radix_ok   = (state.radix == rpup_pkg::RADIX_2) ||
                      (state.radix == rpup_pkg::RADIX_8) ||
                      (state.radix == rpup_pkg::RADIX_10) ||
                      (state.radix == rpup_pkg::RADIX_16);

  `ASSERT_ALWAYS(a_radix_legal, radix_ok, "parser radix is not 2, 8, 10 or 16")
  `ASSERT_NEXT(a_emit_ends_parse, load_result, parse_done && out_valid, "result without end of parse")
  `ASSERT_NEXT(a_stall_holds_state, stalled, $stable(state) && stage_valid, "state moved in a stall")
  `ASSERT_IMPLY(a_ready_only_when_free, !in_ready, stalled, "input blocked without a stalled result")

endmodule

// ===== tb/rpup_checker.sv =====
`timescale 1ns / 100ps
// Checker for the radix-prefixed unsigned parser: watches both channels,
// predicts each parsed number from the accepted characters and compares it
// with the result that comes out. Depends on rpup_pkg.
module rpup_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        first,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] value,
  input  logic [4:0]  radix_used,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] number;
    logic [4:0]  radix;
  } parsed_number_t;

  logic [2:0]     parse_phase = rpup_pkg::PH_DONE;
  logic [4:0]     parse_radix = rpup_pkg::RADIX_10;
  logic [31:0]    parse_accum = '0;
  parsed_number_t pending_numbers[$];
  int             fail_count = 0;

  function automatic logic [31:0] char_digit(input logic [7:0] c);
    logic [31:0] d;
    begin
      d = {24'd0, c} - {24'd0, rpup_pkg::CH_ZERO};
      if (d >= {24'd0, rpup_pkg::ALPHA_FIRST}) begin
        d = (d & ~{24'd0, rpup_pkg::CASE_BIT}) - {24'd0, rpup_pkg::ALPHA_OFFSET};
      end
      return d;
    end
  endfunction

  task automatic take_digit(input logic [7:0] c);
    logic [31:0] d;
    begin
      d = char_digit(c);
      if (d >= {27'd0, parse_radix}) begin
        pending_numbers.push_back({parse_accum, parse_radix});
        parse_phase = rpup_pkg::PH_DONE;
      end else begin
        parse_accum = parse_accum * {27'd0, parse_radix} + d;
        parse_phase = rpup_pkg::PH_DIGITS;
      end
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic start);
    begin
      if (start) begin
        parse_phase = rpup_pkg::PH_SIGN;
        parse_radix = rpup_pkg::RADIX_10;
        parse_accum = '0;
      end
      case (parse_phase)
        rpup_pkg::PH_SIGN: begin
          if (c == rpup_pkg::CH_PLUS) parse_phase = rpup_pkg::PH_LEAD;
          else if (c == rpup_pkg::CH_ZERO) parse_phase = rpup_pkg::PH_ZERO;
          else take_digit(c);
        end
        rpup_pkg::PH_LEAD: begin
          if (c == rpup_pkg::CH_ZERO) parse_phase = rpup_pkg::PH_ZERO;
          else take_digit(c);
        end
        rpup_pkg::PH_ZERO: begin
          parse_accum = '0;
          if (c == rpup_pkg::CH_X) begin
            parse_radix = rpup_pkg::RADIX_16;
            parse_phase = rpup_pkg::PH_DIGITS;
          end else if (c == rpup_pkg::CH_O) begin
            parse_radix = rpup_pkg::RADIX_8;
            parse_phase = rpup_pkg::PH_DIGITS;
          end else if (c == rpup_pkg::CH_B) begin
            parse_radix = rpup_pkg::RADIX_2;
            parse_phase = rpup_pkg::PH_DIGITS;
          end else begin
            parse_radix = rpup_pkg::RADIX_10;
            take_digit(c);
          end
        end
        rpup_pkg::PH_DIGITS: take_digit(c);
        default: parse_phase = rpup_pkg::PH_DONE;
      endcase
    end
  endtask

  task automatic check_number();
    parsed_number_t want;
    begin
      if (pending_numbers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d radix %0d",
                 $time, value, radix_used);
        fail_count++;
      end else begin
        want = pending_numbers.pop_front();
        if (value !== want.number) begin
          $display("%0t: value mismatch, expected %0d, got %0d", $time, want.number, value);
          fail_count++;
        end
        if (radix_used !== want.radix) begin
          $display("%0t: radix mismatch, expected %0d, got %0d",
                   $time, want.radix, radix_used);
          fail_count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_phase = rpup_pkg::PH_DONE;
      parse_radix = rpup_pkg::RADIX_10;
      parse_accum = '0;
      pending_numbers.delete();
    end else begin
      // A result always belongs to an earlier item, so it is checked first.
      if (out_valid && out_ready) check_number();
      if (in_valid && in_ready) parse_char(ch, first);
    end
    errors <= fail_count;
    pending <= pending_numbers.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, character strings in bursts,
// receiver stalls, watchdog and verdict. Depends on rpup_pkg, rpup_checker
// and the radix_prefixed_unsigned_parser block.
module testbench;

  localparam int ITEM_TARGET    = 1000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_AT_ITEM   = 300;
  localparam int PAUSE_AT_ITEM  = 600;

  localparam logic [7:0] CH_BACKQUOTE = 8'h60;
  localparam logic [7:0] CH_LOWER_A   = "a";
  localparam logic [7:0] CH_UPPER_A   = "A";
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_ALL_ONES  = 8'hFF;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_t;
  typedef enum int {PFX_NONE, PFX_ZERO, PFX_HEX, PFX_OCT, PFX_BIN} prefix_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  ch = '0;
  logic        first = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] value;
  logic [4:0]  radix_used;

  int errors;
  int pending;
  int counted_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  radix_prefixed_unsigned_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .first(first),
    .out_valid(out_valid), .out_ready(out_ready), .value(value), .radix_used(radix_used)
  );

  rpup_checker parse_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .first(first),
    .out_valid(out_valid), .out_ready(out_ready), .value(value), .radix_used(radix_used),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       k;
    while (rst) @(posedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (k = 0; k < span; k++) begin
        if (hold_request) begin
          hold_request = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF: out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= (k % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic start, input bit counts);
    begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      burst_left--;
      ch <= c;
      first <= start;
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      if (counts) counted_items++;
    end
  endtask

  task automatic send_text(input string s);
    int i;
    begin
      for (i = 0; i < s.len(); i++) send_char(s[i], i == 0, 1'b1);
    end
  endtask

  function automatic logic [7:0] digit_char(input logic [4:0] base);
    logic [7:0] v;
    begin
      v = 8'($urandom_range(0, base - 1));
      if (v == 8'd9 && $urandom_range(0, 3) == 0) return CH_BACKQUOTE;
      if (v < 8'd10) return rpup_pkg::CH_ZERO + v;
      case ($urandom_range(0, 2))
        0: return rpup_pkg::CH_ZERO + v;
        1: return CH_LOWER_A + v - 8'd10;
        default: return CH_UPPER_A + v - 8'd10;
      endcase
    end
  endfunction

  task automatic send_number_string();
    logic [4:0] base;
    logic       lead;
    int         ndigits;
    int         k;
    begin
      lead = 1'b1;
      base = rpup_pkg::RADIX_10;
      if ($urandom_range(0, 3) == 0) begin
        send_char(rpup_pkg::CH_PLUS, lead, 1'b1);
        lead = 1'b0;
      end
      case (prefix_kind_t'($urandom_range(0, 4)))
        PFX_ZERO: begin
          send_char(rpup_pkg::CH_ZERO, lead, 1'b1);
          lead = 1'b0;
        end
        PFX_HEX: begin
          send_char(rpup_pkg::CH_ZERO, lead, 1'b1);
          send_char(rpup_pkg::CH_X, 1'b0, 1'b1);
          lead = 1'b0;
          base = rpup_pkg::RADIX_16;
        end
        PFX_OCT: begin
          send_char(rpup_pkg::CH_ZERO, lead, 1'b1);
          send_char(rpup_pkg::CH_O, 1'b0, 1'b1);
          lead = 1'b0;
          base = rpup_pkg::RADIX_8;
        end
        PFX_BIN: begin
          send_char(rpup_pkg::CH_ZERO, lead, 1'b1);
          send_char(rpup_pkg::CH_B, 1'b0, 1'b1);
          lead = 1'b0;
          base = rpup_pkg::RADIX_2;
        end
        default: base = rpup_pkg::RADIX_10;
      endcase
      ndigits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 34) : $urandom_range(0, 6);
      for (k = 0; k < ndigits; k++) begin
        send_char(digit_char(base), lead, 1'b1);
        lead = 1'b0;
      end
      // Usually a random byte that may end the parse; else a later byte or the next start ends it.
      if ($urandom_range(0, 9) != 0) send_char(8'($urandom_range(0, 255)), lead, 1'b1);
      repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  task automatic send_noise();
    int k;
    int len;
    begin
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) begin
        send_char(8'($urandom_range(0, 255)), (k == 0) || ($urandom_range(0, 3) == 0), 1'b1);
      end
    end
  endtask

  initial begin : stimulus
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_char("Z", 1'b0, 1'b1);
    send_char(CH_NUL, 1'b1, 1'b1);
    send_text("+");
    send_char(CH_NUL, 1'b0, 1'b1);
    send_text("0xg");
    send_text("+0b102");
    send_text("0o78");
    send_text("1");
    send_text("0X");
    send_char(CH_BACKQUOTE, 1'b0, 1'b1);
    send_char(CH_ALL_ONES, 1'b0, 1'b1);
    send_text("0x:?@");

    while (counted_items < ITEM_TARGET) begin
      if (!held && counted_items >= HOLD_AT_ITEM) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if (!paused && counted_items >= PAUSE_AT_ITEM) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        paused = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_number_string();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rpup_pkg.sv
hw/rtl/rpup_step.sv
hw/rtl/radix_prefixed_unsigned_parser.sv
tb/rpup_checker.sv
tb/testbench.sv
